// ----- design/assert_macros.svh -----
// Assertion macros shared by the cache tag controller RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication checked on every rising clock edge outside reset.
`define ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked on every rising clock edge outside reset.
`define ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ASSERT_IMP(name, clk, rst_n, ante, cons, msg)
`define ASSERT_NXT(name, clk, rst_n, ante, cons, msg)
`endif

`endif

// ----- design/abtc_pkg.sv -----
// Shared constants, codes and control/status types of the cache tag controller.
// No dependencies; used by the interfaces and all modules.
`default_nettype none

package abtc_pkg;

  // Field widths fixed by the beat formats.
  localparam int OPC_W    = 2;
  localparam int DISK_W   = 4;
  localparam int BLOCK_W  = 8;
  localparam int STATUS_W = 2;
  localparam int SLOT_W   = 8;
  localparam int CFG_W    = 9;
  localparam int STAMP_W  = 32;
  localparam int TOTAL_W  = 32;

  // Operation codes.
  localparam logic [OPC_W-1:0] OP_LOOKUP = 2'd0;
  localparam logic [OPC_W-1:0] OP_INSERT = 2'd1;
  localparam logic [OPC_W-1:0] OP_UPDATE = 2'd2;
  localparam logic [OPC_W-1:0] OP_INVAL  = 2'd3;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STS_MISS     = 2'd1;
  localparam logic [STATUS_W-1:0] STS_PRESENT  = 2'd2;
  localparam logic [STATUS_W-1:0] STS_DISABLED = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic scan;
    logic commit;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic skip;
    logic scan_last;
    logic rsp_free;
  } dp_stat_t;

endpackage

`default_nettype wire

// ----- design/abtc_req_if.sv -----
// Request channel: operation and tag of one cache access.
// Depends on abtc_pkg for field widths.
`default_nettype none

interface abtc_req_if;
  logic                            valid;
  logic                            ready;
  logic [abtc_pkg::OPC_W-1:0]      opcode;
  logic [abtc_pkg::DISK_W-1:0]     disk_number;
  logic [abtc_pkg::BLOCK_W-1:0]    block_number;

  modport source (output valid, opcode, disk_number, block_number, input ready);
  modport sink   (input valid, opcode, disk_number, block_number, output ready);
endinterface

`default_nettype wire

// ----- design/abtc_rsp_if.sv -----
// Response channel: status, slot and running totals of one access.
// Depends on abtc_pkg for field widths.
`default_nettype none

interface abtc_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [abtc_pkg::STATUS_W-1:0]   status;
  logic [abtc_pkg::SLOT_W-1:0]     slot_index;
  logic                            evicted;
  logic [abtc_pkg::TOTAL_W-1:0]    hit_total;
  logic [abtc_pkg::TOTAL_W-1:0]    query_total;

  modport source (output valid, status, slot_index, evicted, hit_total, query_total,
                  input ready);
  modport sink   (input valid, status, slot_index, evicted, hit_total, query_total,
                  output ready);
endinterface

`default_nettype wire

// ----- design/abtc_cfg_if.sv -----
// Configuration write channel carrying the number of active slots.
// Depends on abtc_pkg for the data width.
`default_nettype none

interface abtc_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [abtc_pkg::CFG_W-1:0]    data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

// ----- design/assoc_block_tag_cache_mru_top.sv -----
// Tag and replacement controller of a fully associative disk-block cache.
// Each operation scans the n active slots one per cycle through the tag/stamp store
// read port; invalidate-all, disabled and out-of-range inserts skip the scan and
// commit directly, and a new request is taken only once the previous one has committed.
// A response beat held by the sink delays the commit, and the next request, by as long.
// Reset (rst_ni low, asynchronous) clears valid bits, size register and all counters.
`default_nettype none

module assoc_block_tag_cache_mru_top #(
  parameter int MAX_ENTRIES     = 256,
  parameter int DISK_COUNT      = 16,
  parameter int BLOCKS_PER_DISK = 256
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  abtc_req_if.sink     req_i,
  abtc_cfg_if.sink     cfg_i,
  abtc_rsp_if.source   rsp_o
);

  abtc_pkg::ctrl_cmd_t cmd;
  abtc_pkg::dp_stat_t  stat;
  logic                idle;

  // Requests and configuration beats are taken only while idle.
  assign req_i.ready = idle;
  assign cfg_i.ready = idle;

  abtc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .idle_o      (idle),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  abtc_dp #(
    .MAX_ENTRIES     (MAX_ENTRIES),
    .DISK_COUNT      (DISK_COUNT),
    .BLOCKS_PER_DISK (BLOCKS_PER_DISK)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .opcode_i       (req_i.opcode),
    .disk_number_i  (req_i.disk_number),
    .block_number_i (req_i.block_number),
    .cfg_we_i       (cfg_i.valid && idle),
    .cfg_data_i     (cfg_i.data),
    .rsp_ready_i    (rsp_o.ready),
    .rsp_valid_o    (rsp_o.valid),
    .status_o       (rsp_o.status),
    .slot_index_o   (rsp_o.slot_index),
    .evicted_o      (rsp_o.evicted),
    .hit_total_o    (rsp_o.hit_total),
    .query_total_o  (rsp_o.query_total)
  );

endmodule

`default_nettype wire

// ----- design/abtc_dp.sv -----
// Datapath of the cache tag controller: slot stores, scan unit, counters, result register.
// Depends on abtc_pkg; driven by abtc_ctrl through ctrl_cmd_t / dp_stat_t.
`default_nettype none

module abtc_dp #(
  parameter int MAX_ENTRIES     = 256,
  parameter int DISK_COUNT      = 16,
  parameter int BLOCKS_PER_DISK = 256
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire abtc_pkg::ctrl_cmd_t         cmd_i,
  output abtc_pkg::dp_stat_t               stat_o,
  input  wire [abtc_pkg::OPC_W-1:0]        opcode_i,
  input  wire [abtc_pkg::DISK_W-1:0]       disk_number_i,
  input  wire [abtc_pkg::BLOCK_W-1:0]      block_number_i,
  input  wire                              cfg_we_i,
  input  wire [abtc_pkg::CFG_W-1:0]        cfg_data_i,
  input  wire                              rsp_ready_i,
  output logic                             rsp_valid_o,
  output logic [abtc_pkg::STATUS_W-1:0]    status_o,
  output logic [abtc_pkg::SLOT_W-1:0]      slot_index_o,
  output logic                             evicted_o,
  output logic [abtc_pkg::TOTAL_W-1:0]     hit_total_o,
  output logic [abtc_pkg::TOTAL_W-1:0]     query_total_o
);

  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int TAG_W = abtc_pkg::DISK_W + abtc_pkg::BLOCK_W;

  // Captured request.
  logic [abtc_pkg::OPC_W-1:0]   op_q;
  logic [abtc_pkg::DISK_W-1:0]  disk_q;
  logic [abtc_pkg::BLOCK_W-1:0] block_q;

  // Active slot count, valid bits and global counters.
  logic [CNT_W-1:0]             n_q, n_cfg;
  logic [MAX_ENTRIES-1:0]       valid_q, keep_mask;
  logic [abtc_pkg::STAMP_W-1:0] stamp_cnt_q, stamp_nxt;
  logic [abtc_pkg::TOTAL_W-1:0] hit_q, hit_nxt, query_q, query_nxt;

  // Slot stores.
  logic [TAG_W-1:0]             tag_mem   [MAX_ENTRIES];
  logic [abtc_pkg::STAMP_W-1:0] stamp_mem [MAX_ENTRIES];

  // Scan pipeline and search results.
  logic [IDX_W-1:0]             scan_idx_q, rd_idx_q;
  logic                         rd_vld_q, valid_rd_q;
  logic [TAG_W-1:0]             tag_rd_q;
  logic [abtc_pkg::STAMP_W-1:0] stamp_rd_q, max_stamp_q;
  logic                         hit_found_q, free_found_q, max_seen_q;
  logic [IDX_W-1:0]             hit_idx_q, free_idx_q, max_idx_q;

  // Result register.
  logic                            rsp_valid_q;
  logic [abtc_pkg::STATUS_W-1:0]   status_q;
  logic [abtc_pkg::SLOT_W-1:0]     slot_q;
  logic                            evicted_q;

  // Commit decisions.
  logic                          out_of_range;
  logic [abtc_pkg::STATUS_W-1:0] c_status;
  logic [IDX_W-1:0]              c_slot;
  logic                          c_evicted, c_touch, c_tag_we, c_set_valid, c_clear_all;
  logic                          c_hit_inc, c_query_inc;
  logic                          tag_match;

  // Requested size clamped to the store depth, and the slots it keeps.
  always_comb begin
    if (32'(cfg_data_i) > 32'(MAX_ENTRIES)) begin
      n_cfg = CNT_W'(MAX_ENTRIES);
    end else begin
      n_cfg = CNT_W'(cfg_data_i);
    end
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      keep_mask[i] = (32'(i) < 32'(n_cfg));
    end
  end

  // Insert tags beyond the disk geometry are refused.
  assign out_of_range = (32'(disk_q) >= 32'(DISK_COUNT)) ||
                        (32'(block_q) >= 32'(BLOCKS_PER_DISK));

  // Status toward the controller.
  assign stat_o.skip      = (op_q == abtc_pkg::OP_INVAL) || (n_q == '0) ||
                            ((op_q == abtc_pkg::OP_INSERT) && out_of_range);
  assign stat_o.scan_last = ((CNT_W'(scan_idx_q) + CNT_W'(1)) == n_q);
  assign stat_o.rsp_free  = !rsp_valid_q || rsp_ready_i;

  // Capture the request on acceptance.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q    <= opcode_i;
      disk_q  <= disk_number_i;
      block_q <= block_number_i;
    end
  end

  // Slot store read during the scan, written at commit.
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && c_tag_we) begin
      tag_mem[c_slot] <= {disk_q, block_q};
    end
    if (cmd_i.scan) begin
      tag_rd_q <= tag_mem[scan_idx_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && c_touch) begin
      stamp_mem[c_slot] <= stamp_nxt;
    end
    if (cmd_i.scan) begin
      stamp_rd_q <= stamp_mem[scan_idx_q];
      valid_rd_q <= valid_q[scan_idx_q];
      rd_idx_q   <= scan_idx_q;
    end
  end

  // Scan index and search flags.
  assign tag_match = valid_rd_q && (tag_rd_q == {disk_q, block_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_idx_q   <= '0;
      rd_vld_q     <= 1'b0;
      hit_found_q  <= 1'b0;
      free_found_q <= 1'b0;
      max_seen_q   <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.scan;
      if (cmd_i.load) begin
        scan_idx_q   <= '0;
        hit_found_q  <= 1'b0;
        free_found_q <= 1'b0;
        max_seen_q   <= 1'b0;
      end else begin
        if (cmd_i.scan) begin
          scan_idx_q <= scan_idx_q + IDX_W'(1);
        end
        if (rd_vld_q) begin
          if (tag_match) begin
            hit_found_q <= 1'b1;
          end
          if (!valid_rd_q) begin
            free_found_q <= 1'b1;
          end
          max_seen_q <= 1'b1;
        end
      end
    end
  end

  // First match, first free slot and highest stamp (ties keep the lower slot).
  always_ff @(posedge clk_i) begin
    if (rd_vld_q) begin
      if (tag_match && !hit_found_q) begin
        hit_idx_q <= rd_idx_q;
      end
      if (!valid_rd_q && !free_found_q) begin
        free_idx_q <= rd_idx_q;
      end
      if (!max_seen_q || (stamp_rd_q > max_stamp_q)) begin
        max_stamp_q <= stamp_rd_q;
        max_idx_q   <= rd_idx_q;
      end
    end
  end

  // Saturating stamp advance and wrapping totals.
  assign stamp_nxt = (stamp_cnt_q == '1) ? stamp_cnt_q :
                     stamp_cnt_q + abtc_pkg::STAMP_W'(1);
  assign hit_nxt   = hit_q + abtc_pkg::TOTAL_W'(c_hit_inc);
  assign query_nxt = query_q + abtc_pkg::TOTAL_W'(c_query_inc);

  // Outcome of the operation once the scan has finished.
  always_comb begin
    c_status    = abtc_pkg::STS_OK;
    c_slot      = '0;
    c_evicted   = 1'b0;
    c_touch     = 1'b0;
    c_tag_we    = 1'b0;
    c_set_valid = 1'b0;
    c_clear_all = 1'b0;
    c_hit_inc   = 1'b0;
    c_query_inc = 1'b0;
    if (op_q == abtc_pkg::OP_INVAL) begin
      c_clear_all = 1'b1;
    end else if (n_q == '0) begin
      c_status = abtc_pkg::STS_DISABLED;
    end else begin
      case (op_q)
        abtc_pkg::OP_LOOKUP: begin
          c_query_inc = 1'b1;
          if (hit_found_q) begin
            c_hit_inc = 1'b1;
            c_touch   = 1'b1;
            c_slot    = hit_idx_q;
          end else begin
            c_status = abtc_pkg::STS_MISS;
          end
        end
        abtc_pkg::OP_UPDATE: begin
          if (hit_found_q) begin
            c_touch = 1'b1;
            c_slot  = hit_idx_q;
          end else begin
            c_status = abtc_pkg::STS_MISS;
          end
        end
        abtc_pkg::OP_INSERT: begin
          if (out_of_range) begin
            c_status = abtc_pkg::STS_MISS;
          end else if (hit_found_q) begin
            c_status = abtc_pkg::STS_PRESENT;
            c_slot   = hit_idx_q;
          end else begin
            c_slot      = free_found_q ? free_idx_q : max_idx_q;
            c_evicted   = !free_found_q;
            c_touch     = 1'b1;
            c_tag_we    = 1'b1;
            c_set_valid = 1'b1;
          end
        end
        default: begin
          c_status = abtc_pkg::STS_OK;
        end
      endcase
    end
  end

  // Size register, valid bits and counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q         <= '0;
      valid_q     <= '0;
      stamp_cnt_q <= '0;
      hit_q       <= '0;
      query_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        n_q     <= n_cfg;
        valid_q <= valid_q & keep_mask;
      end else if (cmd_i.commit) begin
        if (c_clear_all) begin
          valid_q <= '0;
        end else if (c_set_valid) begin
          valid_q[c_slot] <= 1'b1;
        end
      end
      if (cmd_i.commit) begin
        if (c_touch) begin
          stamp_cnt_q <= stamp_nxt;
        end
        hit_q   <= hit_nxt;
        query_q <= query_nxt;
      end
    end
  end

  // Result register: holds one beat until the sink takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_ready_i) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      status_q  <= c_status;
      slot_q    <= abtc_pkg::SLOT_W'(c_slot);
      evicted_q <= c_evicted;
    end
  end

  assign rsp_valid_o   = rsp_valid_q;
  assign status_o      = status_q;
  assign slot_index_o  = slot_q;
  assign evicted_o     = evicted_q;
  assign hit_total_o   = hit_q;
  assign query_total_o = query_q;

endmodule

`default_nettype wire

// ----- design/abtc_ctrl.sv -----
// Sequencer of the cache tag controller: accept, scan, drain, commit.
// Depends on abtc_pkg and assert_macros.svh; drives abtc_dp.
`default_nettype none
`include "assert_macros.svh"

module abtc_ctrl (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      req_valid_i,
  output logic                     idle_o,
  output abtc_pkg::ctrl_cmd_t      cmd_o,
  input  wire abtc_pkg::dp_stat_t  stat_i
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_START  = 3'd1;
  localparam logic [2:0] ST_SCAN   = 3'd2;
  localparam logic [2:0] ST_DRAIN  = 3'd3;
  localparam logic [2:0] ST_COMMIT = 3'd4;

  logic [2:0] state_q, state_d;

  // Commands for the current state.
  assign idle_o        = (state_q == ST_IDLE);
  assign cmd_o.load    = idle_o && req_valid_i;
  assign cmd_o.scan    = (state_q == ST_SCAN);
  assign cmd_o.commit  = (state_q == ST_COMMIT) && stat_i.rsp_free;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (req_valid_i) begin
          state_d = ST_START;
        end
      end
      ST_START: begin
        state_d = stat_i.skip ? ST_COMMIT : ST_SCAN;
      end
      ST_SCAN: begin
        if (stat_i.scan_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (stat_i.rsp_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // The scan ends on the last active slot and its data is drained once.
  `ASSERT_NXT(a_scan_end, clk_i, rst_ni, cmd_o.scan && stat_i.scan_last, state_q == ST_DRAIN, "scan overran the active slots")
  // A committed beat returns the sequencer to idle.
  `ASSERT_NXT(a_commit_idle, clk_i, rst_ni, cmd_o.commit, idle_o, "sequencer did not return to idle after commit")
  // Load, scan and commit never overlap.
  `ASSERT_IMP(a_cmd_excl, clk_i, rst_ni, 1'b1, $onehot0({cmd_o.load, cmd_o.scan, cmd_o.commit}), "overlapping datapath commands")

endmodule

`default_nettype wire

// ----- dv/assoc_block_tag_cache_mru_top_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench of the disk-block cache tag controller: a directed table, then
// random lookup/insert/update/invalidate traffic, each response checked against a fixed or predicted value.
// Depends on abtc_pkg, the request/response/config interfaces and assoc_block_tag_cache_mru_top.
module assoc_block_tag_cache_mru_top_tb;

  localparam int CLK_PERIOD   = 4;
  localparam int NUM_SLOTS    = 256;
  localparam int NUM_DISKS    = 16;
  localparam int DISK_BLOCKS  = 256;
  localparam int NUM_DIRECTED = 26;
  localparam int NUM_PHASES   = 10;
  localparam int HOLD_CYCLES  = 600;
  localparam int TAIL_CYCLES  = NUM_SLOTS + 16;
  localparam int DRAIN_LIMIT  = 50000;
  localparam int MAX_PRINTED  = 200;

  // One response beat as the checker sees it.
  typedef struct packed {
    logic [abtc_pkg::STATUS_W-1:0] status;
    logic [abtc_pkg::SLOT_W-1:0]   slot;
    logic                          evicted;
    logic [abtc_pkg::TOTAL_W-1:0]  hits;
    logic [abtc_pkg::TOTAL_W-1:0]  queries;
  } cache_rsp_t;

  // One row of the directed table: either a size write or an access.
  typedef struct packed {
    logic                          is_cfg;
    logic [abtc_pkg::CFG_W-1:0]    size;
    logic [abtc_pkg::OPC_W-1:0]    op;
    logic [abtc_pkg::DISK_W-1:0]   disk;
    logic [abtc_pkg::BLOCK_W-1:0]  blk;
    logic                          fixed;
    cache_rsp_t                    rsp;
  } dir_step_t;

  logic clk = 1'b0;
  logic rst_n;

  abtc_req_if req_if ();
  abtc_cfg_if cfg_if ();
  abtc_rsp_if rsp_if ();

  assoc_block_tag_cache_mru_top #(
    .MAX_ENTRIES    (NUM_SLOTS),
    .DISK_COUNT     (NUM_DISKS),
    .BLOCKS_PER_DISK(DISK_BLOCKS)
  ) DUT (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req_if),
    .cfg_i (cfg_if),
    .rsp_o (rsp_if)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Predicted contents of the tag store and the counters.
  bit                            tag_valid [NUM_SLOTS];
  logic [abtc_pkg::DISK_W-1:0]   tag_disk  [NUM_SLOTS];
  logic [abtc_pkg::BLOCK_W-1:0]  tag_blk   [NUM_SLOTS];
  logic [abtc_pkg::STAMP_W-1:0]  tag_stamp [NUM_SLOTS];
  logic [abtc_pkg::STAMP_W-1:0]  stamp_now;
  logic [abtc_pkg::TOTAL_W-1:0]  hit_count;
  logic [abtc_pkg::TOTAL_W-1:0]  query_count;
  logic [abtc_pkg::CFG_W-1:0]    size_reg;

  cache_rsp_t expected_rsps[$];
  int mismatches = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_epoch = 0;
  int hold_seen = 0;
  int hold_left = 0;

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    mismatches++;
    if (mismatches <= MAX_PRINTED)
      $display("%0t: mismatch in %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  // Sizes above the slot count act as the full cache.
  function automatic int active_count();
    return (int'(size_reg) > NUM_SLOTS) ? NUM_SLOTS : int'(size_reg);
  endfunction

  function automatic int find_slot(input logic [abtc_pkg::DISK_W-1:0] disk,
                                   input logic [abtc_pkg::BLOCK_W-1:0] blk);
    int n;
    int i;
    n = active_count();
    for (i = 0; i < n; i++)
      if (tag_valid[i] && tag_disk[i] == disk && tag_blk[i] == blk) return i;
    return -1;
  endfunction

  // The stamp counter saturates instead of wrapping.
  function automatic void refresh_stamp(input int s);
    if (stamp_now != '1) stamp_now++;
    tag_stamp[s] = stamp_now;
  endfunction

  function automatic void reset_prediction();
    int i;
    for (i = 0; i < NUM_SLOTS; i++) begin
      tag_valid[i] = 1'b0;
      tag_disk[i]  = '0;
      tag_blk[i]   = '0;
      tag_stamp[i] = '0;
    end
    stamp_now   = '0;
    hit_count   = '0;
    query_count = '0;
    size_reg    = '0;
  endfunction

  // A size write drops every slot at or above the new size.
  function automatic void apply_size(input logic [abtc_pkg::CFG_W-1:0] v);
    int i;
    size_reg = v;
    for (i = active_count(); i < NUM_SLOTS; i++) tag_valid[i] = 1'b0;
  endfunction

  function automatic cache_rsp_t predict_access(input logic [abtc_pkg::OPC_W-1:0] op,
                                                input logic [abtc_pkg::DISK_W-1:0] disk,
                                                input logic [abtc_pkg::BLOCK_W-1:0] blk);
    cache_rsp_t r;
    int n;
    int s;
    int i;
    r = '0;
    n = active_count();
    if (op == abtc_pkg::OP_INVAL) begin
      for (i = 0; i < NUM_SLOTS; i++) tag_valid[i] = 1'b0;
    end else if (n == 0) begin
      r.status = abtc_pkg::STS_DISABLED;
    end else if (op == abtc_pkg::OP_LOOKUP || op == abtc_pkg::OP_UPDATE) begin
      if (op == abtc_pkg::OP_LOOKUP) query_count++;
      s = find_slot(disk, blk);
      if (s < 0) begin
        r.status = abtc_pkg::STS_MISS;
      end else begin
        r.slot = 8'(s);
        if (op == abtc_pkg::OP_LOOKUP) hit_count++;
        refresh_stamp(s);
      end
    end else if (int'(disk) >= NUM_DISKS || int'(blk) >= DISK_BLOCKS) begin
      r.status = abtc_pkg::STS_MISS;
    end else begin
      s = find_slot(disk, blk);
      if (s >= 0) begin
        r.status = abtc_pkg::STS_PRESENT;
        r.slot   = 8'(s);
      end else begin
        // Lowest free slot, else the most recently used one (lowest index on ties).
        s = -1;
        for (i = 0; i < n && s < 0; i++)
          if (!tag_valid[i]) s = i;
        if (s < 0) begin
          s = 0;
          for (i = 1; i < n; i++)
            if (tag_stamp[i] > tag_stamp[s]) s = i;
          r.evicted = 1'b1;
        end
        tag_valid[s] = 1'b1;
        tag_disk[s]  = disk;
        tag_blk[s]   = blk;
        refresh_stamp(s);
        r.slot = 8'(s);
      end
    end
    r.hits    = hit_count;
    r.queries = query_count;
    return r;
  endfunction

  function automatic dir_step_t checked_req(input logic [abtc_pkg::OPC_W-1:0] op,
                                            input logic [abtc_pkg::DISK_W-1:0] disk,
                                            input logic [abtc_pkg::BLOCK_W-1:0] blk,
                                            input logic [abtc_pkg::STATUS_W-1:0] st,
                                            input logic [abtc_pkg::SLOT_W-1:0] slot,
                                            input logic ev,
                                            input logic [abtc_pkg::TOTAL_W-1:0] hits,
                                            input logic [abtc_pkg::TOTAL_W-1:0] queries);
    dir_step_t d;
    d             = '0;
    d.op          = op;
    d.disk        = disk;
    d.blk         = blk;
    d.fixed       = 1'b1;
    d.rsp.status  = st;
    d.rsp.slot    = slot;
    d.rsp.evicted = ev;
    d.rsp.hits    = hits;
    d.rsp.queries = queries;
    return d;
  endfunction

  function automatic dir_step_t open_req(input logic [abtc_pkg::OPC_W-1:0] op,
                                         input logic [abtc_pkg::DISK_W-1:0] disk,
                                         input logic [abtc_pkg::BLOCK_W-1:0] blk);
    dir_step_t d;
    d      = '0;
    d.op   = op;
    d.disk = disk;
    d.blk  = blk;
    return d;
  endfunction

  function automatic dir_step_t size_step(input logic [abtc_pkg::CFG_W-1:0] v);
    dir_step_t d;
    d        = '0;
    d.is_cfg = 1'b1;
    d.size   = v;
    return d;
  endfunction

  // Directed table: disabled cache, fill, duplicate, hits, misses, eviction of the
  // most recently used slot, oversized and shrinking sizes, invalidate-all.
  function automatic dir_step_t directed_step(input int i);
    case (i)
      0:  return checked_req(abtc_pkg::OP_LOOKUP, 4'd0,  8'd0,
                             abtc_pkg::STS_DISABLED, 8'd0, 1'b0, 0, 0);
      1:  return checked_req(abtc_pkg::OP_INSERT, 4'd15, 8'd255,
                             abtc_pkg::STS_DISABLED, 8'd0, 1'b0, 0, 0);
      2:  return checked_req(abtc_pkg::OP_UPDATE, 4'd0,  8'd0,
                             abtc_pkg::STS_DISABLED, 8'd0, 1'b0, 0, 0);
      3:  return checked_req(abtc_pkg::OP_INVAL,  4'd0,  8'd0,
                             abtc_pkg::STS_OK,       8'd0, 1'b0, 0, 0);
      4:  return size_step(9'd2);
      5:  return checked_req(abtc_pkg::OP_INSERT, 4'd0,  8'd0,
                             abtc_pkg::STS_OK,       8'd0, 1'b0, 0, 0);
      6:  return checked_req(abtc_pkg::OP_INSERT, 4'd15, 8'd255,
                             abtc_pkg::STS_OK,       8'd1, 1'b0, 0, 0);
      7:  return checked_req(abtc_pkg::OP_INSERT, 4'd0,  8'd0,
                             abtc_pkg::STS_PRESENT,  8'd0, 1'b0, 0, 0);
      8:  return checked_req(abtc_pkg::OP_LOOKUP, 4'd15, 8'd255,
                             abtc_pkg::STS_OK,       8'd1, 1'b0, 1, 1);
      9:  return checked_req(abtc_pkg::OP_LOOKUP, 4'd0,  8'd255,
                             abtc_pkg::STS_MISS,     8'd0, 1'b0, 1, 2);
      10: return checked_req(abtc_pkg::OP_UPDATE, 4'd0,  8'd0,
                             abtc_pkg::STS_OK,       8'd0, 1'b0, 1, 2);
      11: return checked_req(abtc_pkg::OP_UPDATE, 4'd15, 8'd0,
                             abtc_pkg::STS_MISS,     8'd0, 1'b0, 1, 2);
      12: return checked_req(abtc_pkg::OP_INSERT, 4'd10, 8'd170,
                             abtc_pkg::STS_OK,       8'd0, 1'b1, 1, 2);
      13: return checked_req(abtc_pkg::OP_LOOKUP, 4'd0,  8'd0,
                             abtc_pkg::STS_MISS,     8'd0, 1'b0, 1, 3);
      14: return open_req(abtc_pkg::OP_LOOKUP, 4'd15, 8'd255);
      15: return open_req(abtc_pkg::OP_INSERT, 4'd5,  8'd90);
      16: return size_step(9'd511);
      17: return open_req(abtc_pkg::OP_INSERT, 4'd3,  8'd12);
      18: return open_req(abtc_pkg::OP_LOOKUP, 4'd10, 8'd170);
      19: return checked_req(abtc_pkg::OP_INVAL,  4'd0,  8'd0,
                             abtc_pkg::STS_OK,       8'd0, 1'b0, 3, 5);
      20: return checked_req(abtc_pkg::OP_LOOKUP, 4'd10, 8'd170,
                             abtc_pkg::STS_MISS,     8'd0, 1'b0, 3, 6);
      21: return size_step(9'd1);
      22: return open_req(abtc_pkg::OP_INSERT, 4'd9,  8'd33);
      23: return open_req(abtc_pkg::OP_INSERT, 4'd6,  8'd204);
      24: return size_step(9'd0);
      25: return checked_req(abtc_pkg::OP_LOOKUP, 4'd6,  8'd204,
                             abtc_pkg::STS_DISABLED, 8'd0, 1'b0, 3, 6);
      default: return '0;
    endcase
  endfunction

  // Random phases: cache size, item count and idle rates of both sides.
  task automatic phase_plan(input int p, output logic [abtc_pkg::CFG_W-1:0] size,
                            output int items, output int send_pct, output int recv_pct);
    case (p)
      0:       begin size = 9'd16;  items = 250; end
      1:       begin size = 9'd1;   items = 150; end
      2:       begin size = 9'd4;   items = 200; end
      3:       begin size = 9'd256; items = 250; end
      4:       begin size = 9'd511; items = 200; end
      5:       begin size = 9'd0;   items = 60;  end
      6:       begin size = 9'd8;   items = 250; end
      7:       begin size = 9'd2;   items = 150; end
      8:       begin size = 9'd33;  items = 200; end
      default: begin size = 9'd12;  items = 90;  end
    endcase
    send_pct = (p < 3) ? 16 : (p < 6) ? 63 : 0;
    recv_pct = (p < 3) ? 63 : (p < 6) ? 16 : 0;
  endtask

  // Offer one access beat and record its expected response once accepted.
  task automatic send_access(input logic [abtc_pkg::OPC_W-1:0] op,
                             input logic [abtc_pkg::DISK_W-1:0] disk,
                             input logic [abtc_pkg::BLOCK_W-1:0] blk, input logic use_fixed,
                             input cache_rsp_t fixed_rsp);
    cache_rsp_t predicted;
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid        <= 1'b1;
    req_if.opcode       <= op;
    req_if.disk_number  <= disk;
    req_if.block_number <= blk;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    predicted = predict_access(op, disk, blk);
    expected_rsps.push_back(use_fixed ? fixed_rsp : predicted);
  endtask

  // Stop offering and wait until every outstanding response has come back.
  task automatic wait_idle();
    req_if.valid <= 1'b0;
    while (expected_rsps.size() != 0) @(posedge clk);
  endtask

  // Size writes only happen with the cache idle.
  task automatic write_size(input logic [abtc_pkg::CFG_W-1:0] v);
    wait_idle();
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= v;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    apply_size(v);
  endtask

  // Response side: random back-pressure, plus a long hold-off when requested.
  always @(posedge clk) begin
    if (!rst_n) begin
      rsp_if.ready <= 1'b0;
    end else if (hold_seen != hold_epoch) begin
      hold_seen = hold_epoch;
      hold_left = HOLD_CYCLES;
      rsp_if.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Compare each accepted response beat with the oldest expectation.
  always @(posedge clk) begin : rsp_check
    cache_rsp_t want;
    if (rsp_if.valid && rsp_if.ready) begin
      if (expected_rsps.size() == 0) begin
        flag_mismatch("response with none outstanding", 32'(rsp_if.slot_index), 0);
      end else begin
        want = expected_rsps.pop_front();
        if (rsp_if.status !== want.status)
          flag_mismatch("status", 32'(rsp_if.status), 32'(want.status));
        if (rsp_if.slot_index !== want.slot)
          flag_mismatch("slot_index", 32'(rsp_if.slot_index), 32'(want.slot));
        if (rsp_if.evicted !== want.evicted)
          flag_mismatch("evicted", 32'(rsp_if.evicted), 32'(want.evicted));
        if (rsp_if.hit_total !== want.hits)
          flag_mismatch("hit_total", rsp_if.hit_total, want.hits);
        if (rsp_if.query_total !== want.queries)
          flag_mismatch("query_total", rsp_if.query_total, want.queries);
      end
    end
  end

  initial begin : stimulus
    dir_step_t                   step;
    logic [abtc_pkg::CFG_W-1:0]  size;
    logic [11:0]                 base;
    logic [11:0]                 stride;
    logic [11:0]                 tag;
    logic [abtc_pkg::OPC_W-1:0]  op;
    int items;
    int send_pct;
    int recv_pct;
    int n;
    int pool_n;
    int cursor;
    int hi;
    int pick;
    int p;
    int k;
    rst_n               = 1'b0;
    req_if.valid        = 1'b0;
    req_if.opcode       = abtc_pkg::OP_LOOKUP;
    req_if.disk_number  = '0;
    req_if.block_number = '0;
    cfg_if.valid        = 1'b0;
    cfg_if.data         = '0;
    reset_prediction();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table.
    send_idle_pct = 16;
    recv_idle_pct = 63;
    for (k = 0; k < NUM_DIRECTED; k++) begin
      step = directed_step(k);
      if (step.is_cfg) write_size(step.size);
      else send_access(step.op, step.disk, step.blk, step.fixed, step.rsp);
    end

    // Random phases over a pool of distinct tags so that hits and evictions are common.
    for (p = 0; p < NUM_PHASES; p++) begin
      phase_plan(p, size, items, send_pct, recv_pct);
      write_size(size);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      if (p == 0 || p == 6) hold_epoch++;
      n      = (int'(size) > NUM_SLOTS) ? NUM_SLOTS : int'(size);
      pool_n = 2 * n + 2;
      cursor = 0;
      base   = 12'($urandom);
      stride = 12'($urandom) | 12'd1;
      for (k = 0; k < items; k++) begin
        pick = $urandom_range(99);
        if (n >= 128) begin
          // Large caches: insert-heavy with fresh tags so the cache fills and evicts.
          op = (pick < 60) ? abtc_pkg::OP_INSERT :
               (pick < 85) ? abtc_pkg::OP_LOOKUP : abtc_pkg::OP_UPDATE;
        end else if (pick < 3) begin
          op = abtc_pkg::OP_INVAL;
        end else begin
          op = (pick < 40) ? abtc_pkg::OP_INSERT :
               (pick < 75) ? abtc_pkg::OP_LOOKUP : abtc_pkg::OP_UPDATE;
        end
        if ($urandom_range(99) < 15) begin
          tag = 12'($urandom);
        end else if (op == abtc_pkg::OP_INSERT && (n >= 128 || $urandom_range(1) == 1)) begin
          tag    = base + 12'(cursor) * stride;
          cursor = (cursor + 1) % pool_n;
        end else begin
          hi  = (n >= 128 && cursor + 2 < pool_n) ? cursor + 2 : pool_n;
          tag = base + 12'($urandom_range(hi - 1)) * stride;
        end
        send_access(op, tag[11:8], tag[7:0], 1'b0, '0);
      end
    end

    // Drain, then give a stray late beat time to show up.
    req_if.valid <= 1'b0;
    k = 0;
    while (expected_rsps.size() != 0 && k < DRAIN_LIMIT) begin
      @(posedge clk);
      k++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_rsps.size() != 0)
      flag_mismatch("responses never returned", expected_rsps.size(), 0);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Hard limit on the run.
  initial begin
    #(10_000_000);
    $display("Verification failed");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+design
design/abtc_pkg.sv
design/abtc_req_if.sv
design/abtc_rsp_if.sv
design/abtc_cfg_if.sv
design/abtc_dp.sv
design/abtc_ctrl.sv
design/assoc_block_tag_cache_mru_top.sv
dv/assoc_block_tag_cache_mru_top_tb.sv
